// ===== hdl/spi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package spi_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int REG_IDX_WIDTH   = 2;

	// configuration register map
	localparam logic [REG_IDX_WIDTH-1:0] REG_NORMAL_X     = 2'd0;
	localparam logic [REG_IDX_WIDTH-1:0] REG_NORMAL_Y     = 2'd1;
	localparam logic [REG_IDX_WIDTH-1:0] REG_NORMAL_Z     = 2'd2;
	localparam logic [REG_IDX_WIDTH-1:0] REG_PLANE_OFFSET = 2'd3;

	// per-request control that rides along the divider and interpolator
	typedef struct packed {
		logic vld;
		logic hit;
		logic neg;
	} spi_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/spi_dot.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spi_dot import spi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  ce,
	input  wire logic                                  vld_i,
	input  wire logic signed [COORD_WIDTH-1:0]         start_i [3],
	input  wire logic signed [COORD_WIDTH-1:0]         end_i [3],
	input  wire logic signed [COORD_WIDTH-1:0]         normal_i [3],
	input  wire logic signed [COORD_WIDTH-1:0]         offset_i,
	output logic                                       vld_o,
	output logic signed [COORD_WIDTH-1:0]              v1_o [3],
	output logic signed [COORD_WIDTH:0]                d_o [3],
	output logic signed [2*COORD_WIDTH+3:0]            ra_o,
	output logic signed [2*COORD_WIDTH+3:0]            dot_o
);
	localparam int W = 2*COORD_WIDTH + 4;

	logic                            vld_s1, vld_s2, vld_s3;
	logic signed [COORD_WIDTH-1:0]   v1_s1 [3], v1_s2 [3], v1_s3 [3];
	logic signed [COORD_WIDTH:0]     d_s1 [3], d_s2 [3], d_s3 [3];
	logic signed [2*COORD_WIDTH-1:0] pa_s2 [3];
	logic signed [2*COORD_WIDTH:0]   pd_s2 [3];
	logic signed [W-1:0]             ra_s3, dot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				v1_s1[i] <= start_i[i];
				d_s1[i]  <= (COORD_WIDTH+1)'(end_i[i]) - (COORD_WIDTH+1)'(start_i[i]);
				pa_s2[i] <= normal_i[i] * v1_s1[i];
				pd_s2[i] <= normal_i[i] * d_s1[i];
				v1_s2[i] <= v1_s1[i];
				d_s2[i]  <= d_s1[i];
				v1_s3[i] <= v1_s2[i];
				d_s3[i]  <= d_s2[i];
			end
			ra_s3  <= W'(pa_s2[0]) + W'(pa_s2[1]) + W'(pa_s2[2])
				- (W'(offset_i) <<< FRAC_BITS);
			dot_s3 <= W'(pd_s2[0]) + W'(pd_s2[1]) + W'(pd_s2[2]);
		end
	end

	assign vld_o = vld_s3;
	assign v1_o  = v1_s3;
	assign d_o   = d_s3;
	assign ra_o  = ra_s3;
	assign dot_o = dot_s3;

endmodule
`default_nettype wire

// ===== hdl/spi_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spi_div import spi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               ce,
	input  wire logic                               vld_i,
	input  wire logic signed [2*COORD_WIDTH+3:0]    ra_i,
	input  wire logic signed [2*COORD_WIDTH+3:0]    dot_i,
	input  wire logic signed [COORD_WIDTH-1:0]      v1_i [3],
	input  wire logic signed [COORD_WIDTH:0]        d_i [3],
	output spi_ctl_t                                ctl_o,
	output logic [COORD_WIDTH+2:0]                  q_o,
	output logic signed [COORD_WIDTH-1:0]           v1_o [3],
	output logic signed [COORD_WIDTH:0]             d_o [3]
);
	localparam int W  = 2*COORD_WIDTH + 4;
	localparam int R  = W + 1;
	localparam int QW = COORD_WIDTH + 3;

	logic signed [W-1:0]           rb;
	spi_ctl_t                      ctl_in;
	spi_ctl_t                      ctl_p [QW+1];
	logic [R-1:0]                  rem_p [QW+1];
	logic [R-1:0]                  ud_p  [QW+1];
	logic [QW-1:0]                 q_p   [QW+1];
	logic signed [COORD_WIDTH-1:0] v1_p  [QW+1][3];
	logic signed [COORD_WIDTH:0]   d_p   [QW+1][3];

	// rb = ra + dot exactly, so the side test needs no second dot product
	always_comb begin
		rb         = ra_i + dot_i;
		ctl_in.vld = vld_i;
		ctl_in.hit = (ra_i[W-1] != rb[W-1]) && (dot_i != '0);
		ctl_in.neg = ((ra_i != '0) && !ra_i[W-1]) != dot_i[W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_p[0] <= '0;
		end else if (ce) begin
			ctl_p[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_p[0] <= ra_i[W-1]  ? -R'(ra_i)  : R'(ra_i);
			ud_p[0]  <= dot_i[W-1] ? -R'(dot_i) : R'(dot_i);
			q_p[0]   <= '0;
			v1_p[0]  <= v1_i;
			d_p[0]   <= d_i;
		end
	end

	// one restoring quotient bit per stage; the first bit has no shift
	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [R-1:0] t;
		logic         ge;

		always_comb begin
			t  = (k == 1) ? rem_p[k-1] : (rem_p[k-1] << 1);
			ge = t >= ud_p[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_p[k] <= '0;
			end else if (ce) begin
				ctl_p[k] <= ctl_p[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_p[k] <= ge ? t - ud_p[k-1] : t;
				q_p[k]   <= {q_p[k-1][QW-2:0], ge};
				ud_p[k]  <= ud_p[k-1];
				v1_p[k]  <= v1_p[k-1];
				d_p[k]   <= d_p[k-1];
			end
		end
	end

	assign ctl_o = ctl_p[QW];
	assign q_o   = q_p[QW];
	assign v1_o  = v1_p[QW];
	assign d_o   = d_p[QW];

endmodule
`default_nettype wire

// ===== hdl/spi_interp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spi_interp import spi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               ce,
	input  wire spi_ctl_t                           ctl_i,
	input  wire logic [COORD_WIDTH+2:0]             q_i,
	input  wire logic signed [COORD_WIDTH-1:0]      v1_i [3],
	input  wire logic signed [COORD_WIDTH:0]        d_i [3],
	output logic                                    vld_o,
	output logic                                    hit_o,
	output logic signed [COORD_WIDTH-1:0]           point_o [3]
);
	localparam int LB = COORD_WIDTH + 2;
	localparam int LW = COORD_WIDTH + 4;
	localparam int P  = 2*COORD_WIDTH + 5;

	spi_ctl_t                      ctl_m;
	logic signed [LW-1:0]          lam;
	logic signed [P-1:0]           prod_m [3];
	logic signed [COORD_WIDTH-1:0] v1_m [3];
	logic signed [P-1:0]           sum [3];
	logic signed [COORD_WIDTH-1:0] pt [3];
	logic signed [P-1:0]           hi_lim, lo_lim;
	logic                          vld_q, hit_q;
	logic signed [COORD_WIDTH-1:0] point_q [3];

	always_comb begin
		lam    = ctl_i.neg ? -LW'(q_i) : LW'(q_i);
		hi_lim = P'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}}));
		lo_lim = P'($signed({1'b1, {(COORD_WIDTH-1){1'b0}}}));
		for (int i = 0; i < 3; i++) begin
			// round half up, then saturate
			sum[i] = P'(v1_m[i])
				+ ((prod_m[i] + (P'(1) <<< (LB-1))) >>> LB);
			if (!ctl_m.hit)
				pt[i] = '0;
			else if (sum[i] > hi_lim)
				pt[i] = hi_lim[COORD_WIDTH-1:0];
			else if (sum[i] < lo_lim)
				pt[i] = lo_lim[COORD_WIDTH-1:0];
			else
				pt[i] = sum[i][COORD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_m <= '0;
			vld_q <= 1'b0;
		end else if (ce) begin
			ctl_m <= ctl_i;
			vld_q <= ctl_m.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				prod_m[i]  <= d_i[i] * lam;
				v1_m[i]    <= v1_i[i];
				point_q[i] <= pt[i];
			end
			hit_q <= ctl_m.hit;
		end
	end

	assign vld_o   = vld_q;
	assign hit_o   = hit_q;
	assign point_o = point_q;

endmodule
`default_nettype wire

// ===== hdl/segment_plane_intersection.sv =====
// Throughput: one request per cycle unless stalled; one quotient bit per divider stage.
// Stall: the whole pipeline holds while the output register is full and not taken.
// Reset: arst_n clears all valid bits and the plane registers to zero.
// Plane registers are written through wr_en/wr_index/wr_data, no read-back.
`timescale 1ns / 1ps
`default_nettype none
module segment_plane_intersection import spi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [REG_IDX_WIDTH-1:0]        wr_index,
	input  wire logic [COORD_WIDTH-1:0]          wr_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [COORD_WIDTH-1:0]   start_x,
	input  wire logic signed [COORD_WIDTH-1:0]   start_y,
	input  wire logic signed [COORD_WIDTH-1:0]   start_z,
	input  wire logic signed [COORD_WIDTH-1:0]   end_x,
	input  wire logic signed [COORD_WIDTH-1:0]   end_y,
	input  wire logic signed [COORD_WIDTH-1:0]   end_z,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 hit,
	output logic signed [COORD_WIDTH-1:0]        point_x,
	output logic signed [COORD_WIDTH-1:0]        point_y,
	output logic signed [COORD_WIDTH-1:0]        point_z
);
	// plane registers
	logic signed [COORD_WIDTH-1:0] normal_q [3];
	logic signed [COORD_WIDTH-1:0] offset_q;

	// pipeline interconnect
	logic                          ce;
	logic signed [COORD_WIDTH-1:0] start_v [3], end_v [3];
	logic                          dot_vld;
	logic signed [COORD_WIDTH-1:0] dot_v1 [3];
	logic signed [COORD_WIDTH:0]   dot_d [3];
	logic signed [2*COORD_WIDTH+3:0] dot_ra, dot_dot;
	spi_ctl_t                      div_ctl;
	logic [COORD_WIDTH+2:0]        div_q;
	logic signed [COORD_WIDTH-1:0] div_v1 [3];
	logic signed [COORD_WIDTH:0]   div_d [3];
	logic signed [COORD_WIDTH-1:0] point [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q <= '{default: '0};
			offset_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_NORMAL_X:     normal_q[0] <= wr_data;
				REG_NORMAL_Y:     normal_q[1] <= wr_data;
				REG_NORMAL_Z:     normal_q[2] <= wr_data;
				REG_PLANE_OFFSET: offset_q    <= wr_data;
				default: ;
			endcase
		end
	end

	// Single global advance: everything moves when the output slot is free
	// or being drained this cycle.
	assign ce       = !out_valid || out_ready;
	assign in_ready = ce;

	assign start_v = '{start_x, start_y, start_z};
	assign end_v   = '{end_x, end_y, end_z};

	// side tests and dot products: three stages
	spi_dot #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dot (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.vld_i   (in_valid && in_ready),
		.start_i (start_v),
		.end_i   (end_v),
		.normal_i(normal_q),
		.offset_i(offset_q),
		.vld_o   (dot_vld),
		.v1_o    (dot_v1),
		.d_o     (dot_d),
		.ra_o    (dot_ra),
		.dot_o   (dot_dot)
	);

	// hit decision plus restoring divide for lambda
	spi_div #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ce    (ce),
		.vld_i (dot_vld),
		.ra_i  (dot_ra),
		.dot_i (dot_dot),
		.v1_i  (dot_v1),
		.d_i   (dot_d),
		.ctl_o (div_ctl),
		.q_o   (div_q),
		.v1_o  (div_v1),
		.d_o   (div_d)
	);

	// v1 + lambda * d, rounded and saturated; holds the output register
	spi_interp #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.ce     (ce),
		.ctl_i  (div_ctl),
		.q_i    (div_q),
		.v1_i   (div_v1),
		.d_i    (div_d),
		.vld_o  (out_valid),
		.hit_o  (hit),
		.point_o(point)
	);

	assign point_x = point[0];
	assign point_y = point[1];
	assign point_z = point[2];

	// a miss always carries a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> point_x == '0 && point_y == '0 && point_z == '0)
		else $error("miss with nonzero point");

	// backpressure only comes from a full, untaken output register
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a held result keeps the input side closed
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && (out_ready || !in_ready))
		else $error("held result lost or input open");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import spi_pkg::*;

	localparam int CW        = COORD_WIDTH_DEF;
	localparam int FB        = FRAC_BITS_DEF;
	localparam int LAMB      = CW + 2;       // quotient fraction bits
	localparam int PIPE_LAT  = CW + 9;       // request accept to result valid
	localparam int MAX_GAP   = 17;
	localparam int HOLD_LEN  = 400;          // long receiver hold-off
	localparam int CYC_LIMIT = 1000000;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t sx, sy, sz, ex, ey, ez;
	} segment_t;

	typedef struct {
		logic   hit;
		coord_t px, py, pz;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_WIDTH-1:0] wr_index = '0;
	logic [CW-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	coord_t start_x = '0, start_y = '0, start_z = '0;
	coord_t end_x = '0, end_y = '0, end_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	coord_t point_x, point_y, point_z;

	segment_t  seg_pending[$];   // segments waiting to be offered
	crossing_t crossing_due[$];  // predicted results, oldest first
	segment_t  seg_on_bus;

	// shadow of the plane registers
	coord_t plane_nx = '0, plane_ny = '0, plane_nz = '0, plane_c = '0;

	int  err_cnt = 0;
	int  req_cnt = 0;
	int  rsp_cnt = 0;
	int  hit_cnt = 0;
	int  cfg_cnt = 0;
	int  cyc_cnt = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	bit  send_burst = 0;   // no idling on the request side when set
	bit  recv_burst = 0;
	bit  hold_off = 0;

	always #5 clk = ~clk;

	segment_plane_intersection u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.start_x  (start_x),
		.start_y  (start_y),
		.start_z  (start_z),
		.end_x    (end_x),
		.end_y    (end_y),
		.end_z    (end_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit      (hit),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z)
	);

	// Exact segment/plane crossing at 128 bits.
	// Side test: r = n.v - (c << FB); zero counts as the non-negative side.
	// lam = floor(|r1| * 2^LAMB / |n.d|) with the sign of -r1 / n.d,
	// offset rounded half up, point saturated to CW bits.
	function automatic crossing_t plane_crossing(segment_t s);
		logic signed [127:0] n[3], a[3], b[3], d[3];
		logic signed [127:0] c, r1, r2, dn, lam, p, lim_hi, lim_lo;
		logic [127:0] un, ud, q;
		logic num_neg;
		crossing_t res;
		n[0] = plane_nx; n[1] = plane_ny; n[2] = plane_nz;
		a[0] = s.sx; a[1] = s.sy; a[2] = s.sz;
		b[0] = s.ex; b[1] = s.ey; b[2] = s.ez;
		for (int i = 0; i < 3; i++)
			d[i] = b[i] - a[i];
		c = plane_c;
		c = c <<< FB;
		r1 = n[0] * a[0] + n[1] * a[1] + n[2] * a[2] - c;
		r2 = n[0] * b[0] + n[1] * b[1] + n[2] * b[2] - c;
		dn = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
		res.hit = 1'b0;
		res.px = '0; res.py = '0; res.pz = '0;
		if (r1[127] == r2[127] || dn == 0)
			return res;
		un = r1[127] ? -r1 : r1;
		ud = dn[127] ? -dn : dn;
		q = (un << LAMB) / ud;
		lam = signed'(q);
		num_neg = !r1[127] && (r1 != 0);   // numerator is -r1
		if (num_neg != dn[127])
			lam = -lam;
		lim_hi = (128'sd1 <<< (CW - 1)) - 1;
		lim_lo = -lim_hi - 1;
		res.hit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			p = a[i] + ((d[i] * lam + (128'sd1 <<< (LAMB - 1))) >>> LAMB);
			if (p > lim_hi) p = lim_hi;
			if (p < lim_lo) p = lim_lo;
			case (i)
				0: res.px = p[CW-1:0];
				1: res.py = p[CW-1:0];
				default: res.pz = p[CW-1:0];
			endcase
		end
		return res;
	endfunction

	function automatic int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Request driver: holds valid and payload until accepted.
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid) begin
				crossing_due.push_back(plane_crossing(seg_on_bus));
				req_cnt <= req_cnt + 1;
			end
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (seg_pending.size() != 0) begin
				segment_t s;
				s = seg_pending.pop_front();
				seg_on_bus <= s;
				start_x <= s.sx; start_y <= s.sy; start_z <= s.sz;
				end_x   <= s.ex; end_y   <= s.ey; end_z   <= s.ez;
				in_valid <= 1'b1;
				send_gap <= draw_gap(send_burst);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(string fname, logic [CW-1:0] want, logic [CW-1:0] got);
		if (want !== got) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("MISMATCH result %0d %s: expected %h got %h",
					rsp_cnt, fname, want, got);
		end
	endtask

	// Result monitor and receiver-side stall generator.
	always @(posedge clk) begin
		int nxt_gap;
		crossing_t want;
		nxt_gap = recv_gap;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (crossing_due.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("MISMATCH unexpected result hit=%b", hit);
				end else begin
					want = crossing_due.pop_front();
					check_field("hit", CW'(want.hit), CW'(hit));
					check_field("point_x", want.px, point_x);
					check_field("point_y", want.py, point_y);
					check_field("point_z", want.pz, point_z);
				end
				if (hit) hit_cnt <= hit_cnt + 1;
				rsp_cnt <= rsp_cnt + 1;
				nxt_gap = draw_gap(recv_burst);
			end else if (recv_gap != 0) begin
				nxt_gap = recv_gap - 1;
			end
			recv_gap <= nxt_gap;
			out_ready <= !hold_off && nxt_gap == 0;
		end
	end

	// Long receiver hold-off while requests keep coming, fills the pipe.
	initial begin
		wait (req_cnt >= 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt > CYC_LIMIT) begin
			$display("timeout after %0d cycles", cyc_cnt);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_plane(coord_t nx, coord_t ny, coord_t nz, coord_t c);
		coord_t v[4];
		v[0] = nx; v[1] = ny; v[2] = nz; v[3] = c;
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			wr_en <= 1'b1;
			case (i)
				0: wr_index <= REG_NORMAL_X;
				1: wr_index <= REG_NORMAL_Y;
				2: wr_index <= REG_NORMAL_Z;
				default: wr_index <= REG_PLANE_OFFSET;
			endcase
			wr_data <= v[i];
		end
		@(posedge clk);
		wr_en <= 1'b0;
		plane_nx <= nx; plane_ny <= ny; plane_nz <= nz; plane_c <= c;
		cfg_cnt++;
		@(posedge clk);
	endtask

	// wait for the pipe to drain so the plane can change
	task automatic wait_idle();
		wait (seg_pending.size() == 0 && !in_valid && crossing_due.size() == 0);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	function automatic coord_t rnd_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
			default:
				case ($urandom_range(0, 4))
					0: return coord_t'(32'h8000_0000);
					1: return coord_t'(32'h7fff_ffff);
					2: return '0;
					3: return coord_t'(32'hffff_ffff);
					default: return coord_t'($urandom);
				endcase
		endcase
	endfunction

	function automatic segment_t rnd_segment();
		segment_t s;
		int mode;
		mode = $urandom_range(0, 9) < 4 ? 0 : ($urandom_range(0, 9) < 8 ? 1 : 2);
		s.sx = rnd_coord(mode); s.sy = rnd_coord(mode); s.sz = rnd_coord(mode);
		s.ex = rnd_coord(mode); s.ey = rnd_coord(mode); s.ez = rnd_coord(mode);
		return s;
	endfunction

	function automatic segment_t mk(int sx, int sy, int sz, int ex, int ey, int ez);
		segment_t s;
		s.sx = sx; s.sy = sy; s.sz = sz; s.ex = ex; s.ey = ey; s.ez = ez;
		return s;
	endfunction

	initial begin
		localparam int ONE = 1 << FB;
		localparam int MINV = 32'h8000_0000;
		localparam int MAXV = 32'h7fff_ffff;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: plane x = 1.0
		write_plane(ONE, 0, 0, ONE);
		seg_pending.push_back(mk(0, 0, 0, 2 * ONE, 0, 0));           // plain crossing
		seg_pending.push_back(mk(2 * ONE, 5, -7, 0, 9, 3));          // reverse direction
		seg_pending.push_back(mk(ONE, 3, 4, 0, 3, 4));               // start on plane, end below
		seg_pending.push_back(mk(0, 3, 4, ONE, 3, 4));               // end on plane, start below
		seg_pending.push_back(mk(2 * ONE, 3, 4, ONE, 3, 4));         // end on plane, start above
		seg_pending.push_back(mk(ONE, 0, 0, ONE, ONE, ONE));         // both on plane
		seg_pending.push_back(mk(0, 0, 0, 0, ONE, ONE));             // parallel, below
		seg_pending.push_back(mk(3 * ONE, 0, 0, 5 * ONE, 0, 0));     // both above
		seg_pending.push_back(mk(MINV, MINV, MINV, MAXV, MAXV, MAXV)); // full span
		seg_pending.push_back(mk(MAXV, MINV, MAXV, MINV, MAXV, MINV));
		seg_pending.push_back(mk(MINV, MAXV, 0, 2 * ONE, MINV, MAXV));
		seg_pending.push_back(mk(-1, -1, -1, MAXV, 0, 0));
		seg_pending.push_back(mk(ONE - 1, 0, 0, ONE + 1, MAXV, MINV)); // tiny step
		seg_pending.push_back(mk(0, 0, 0, 0, 0, 0));                 // degenerate
		wait_idle();

		// Directed: extreme plane registers
		write_plane(MINV, MAXV, MINV, MAXV);
		seg_pending.push_back(mk(MINV, MINV, MINV, MAXV, MAXV, MAXV));
		seg_pending.push_back(mk(MAXV, MAXV, MAXV, MINV, MINV, MINV));
		seg_pending.push_back(mk(0, 0, 0, MAXV, MINV, MAXV));
		seg_pending.push_back(mk(MINV, 0, MAXV, 1, -1, 1));
		seg_pending.push_back(mk(ONE, -ONE, ONE, -ONE, ONE, -ONE));
		wait_idle();

		// Random phases, each with its own plane
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: write_plane(0, 0, 0, coord_t'($urandom));          // zero normal
				1: write_plane(MAXV, MAXV, MAXV, MINV);
				2: write_plane(ONE, -ONE, ONE / 2, 0);
				default: write_plane(rnd_coord(ph % 3), rnd_coord(ph % 3),
					rnd_coord(ph % 3), rnd_coord(ph % 3));
			endcase
			send_burst = (ph == 3);
			recv_burst = (ph == 4);
			for (int k = 0; k < 210; k++)
				seg_pending.push_back(rnd_segment());
			wait_idle();
		end

		send_burst = 1; recv_burst = 1;
		wait (crossing_due.size() == 0 && !in_valid);
		repeat (PIPE_LAT + 20) @(posedge clk);
		err_cnt += crossing_due.size();

		$display("covered %0d segments (%0d hits) over %0d plane settings, long output stall",
			req_cnt, hit_cnt, cfg_cnt);
		$display("results checked: %0d, mismatches: %0d", rsp_cnt, err_cnt);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/spi_pkg.sv
hdl/spi_dot.sv
hdl/spi_div.sv
hdl/spi_interp.sv
hdl/segment_plane_intersection.sv
tb/tb_top.sv
